>>> hdl/cpfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpfm_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int CAP_W    = 16;
  localparam int TMO_W    = 16;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd6408;
  localparam logic [DATA_W-1:0] CLOCK_RESET   = 32'd84000000;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK   = 1'b1;

  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_WAIT      = 3'd0;
  localparam logic [STEP_W-1:0] ST_UPDATE    = 3'd1;
  localparam logic [STEP_W-1:0] ST_DIV_INIT  = 3'd2;
  localparam logic [STEP_W-1:0] ST_DIV_STEP  = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT_WAIT = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT      = 3'd5;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_REQ,
    JC_PERIOD_ZERO,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jump_t;

  typedef struct packed {
    logic              take_req;
    logic              update;
    logic              div_init;
    logic              div_step;
    logic              load_out;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic period_zero;
    logic div_more;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    w.jump   = JC_NEVER;
    w.target = ST_WAIT;
    case (step)
      ST_WAIT: begin
        w.take_req = 1'b1;
        w.jump     = JC_NO_REQ;
        w.target   = ST_WAIT;
      end
      ST_UPDATE: begin
        w.update = 1'b1;
      end
      ST_DIV_INIT: begin
        w.div_init = 1'b1;
        w.jump     = JC_PERIOD_ZERO;
        w.target   = ST_EMIT_WAIT;
      end
      ST_DIV_STEP: begin
        w.div_step = 1'b1;
        w.jump     = JC_DIV_MORE;
        w.target   = ST_DIV_STEP;
      end
      ST_EMIT_WAIT: begin
        w.jump   = JC_OUT_BUSY;
        w.target = ST_EMIT_WAIT;
      end
      ST_EMIT: begin
        w.load_out = 1'b1;
        w.jump     = JC_ALWAYS;
        w.target   = ST_WAIT;
      end
      default: begin
        w.jump   = JC_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cpfm_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module cpfm_sequencer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  input  wire cpfm_pkg::status_t status,
  output cpfm_pkg::ctrl_t      ctrl
);
  import cpfm_pkg::*;

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic              taken;

  assign ctrl = ucode_word(pc_r);

  always_comb begin
    case (ctrl.jump)
      JC_NEVER:       taken = 1'b0;
      JC_ALWAYS:      taken = 1'b1;
      JC_NO_REQ:      taken = !req_valid;
      JC_PERIOD_ZERO: taken = status.period_zero;
      JC_DIV_MORE:    taken = status.div_more;
      JC_OUT_BUSY:    taken = status.out_busy;
      default:        taken = 1'b1;
    endcase
    pc_nxt = taken ? ctrl.target : pc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cpfm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cpfm_datapath #(
  parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cpfm_pkg::ctrl_t                ctrl,
  output cpfm_pkg::status_t                   status,
  input  wire logic                           req_valid,
  input  wire logic                           req_operation,
  input  wire logic [cpfm_pkg::CAP_W-1:0]     req_count,
  input  wire logic                           cfg_write_en,
  input  wire logic [cpfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpfm_pkg::DATA_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cpfm_pkg::DATA_W-1:0]         out_period_ticks,
  output logic [cpfm_pkg::DATA_W-1:0]         out_frequency_hz,
  output logic                                out_armed
);
  import cpfm_pkg::*;

  localparam logic [CAP_W-1:0] CAP_MASK =
    (COUNTER_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((1 << COUNTER_BITS) - 1);

  logic [TMO_W-1:0]     timeout_r;
  logic [DATA_W-1:0]    clock_r;
  logic                 op_r;
  logic [CAP_W-1:0]     cap_r;
  logic                 armed_r;
  logic [CAP_W-1:0]     last_r;
  logic [TMO_W-1:0]     ovf_r;
  logic [DATA_W-1:0]    period_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_period_r;
  logic [DATA_W-1:0]    out_freq_r;
  logic                 out_armed_r;

  logic [DATA_W-1:0]    wrap_term;
  logic [DATA_W-1:0]    new_period;
  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    trial;
  logic                 fits;

  always_comb begin
    if (COUNTER_BITS >= DATA_W) begin
      wrap_term = '0;
    end else begin
      wrap_term = {{(DATA_W-TMO_W){1'b0}}, ovf_r} << COUNTER_BITS;
    end
    new_period = {{(DATA_W-CAP_W){1'b0}}, cap_r} + wrap_term
               - {{(DATA_W-CAP_W){1'b0}}, last_r};
    shifted    = {rem_r, quo_r[DATA_W-1]};
    trial      = {1'b0, shifted} - {2'b00, period_r};
    fits       = !trial[DATA_W+1];
  end

  assign status.period_zero = (period_r == '0);
  assign status.div_more    = (cnt_r != {DIV_CNT_W{1'b1}});
  assign status.out_busy    = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      clock_r   <= CLOCK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_r <= cfg_wdata[TMO_W-1:0];
        REG_CLOCK:   clock_r   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_req && req_valid) begin
      op_r  <= req_operation;
      cap_r <= req_count & CAP_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      last_r   <= '0;
      ovf_r    <= '0;
      period_r <= '0;
    end else if (ctrl.update) begin
      if (op_r == OP_CAPTURE) begin
        if (armed_r) begin
          period_r <= new_period;
        end
        last_r  <= cap_r;
        ovf_r   <= '0;
        armed_r <= 1'b1;
      end else if (ovf_r < timeout_r) begin
        ovf_r <= ovf_r + TMO_W'(1);
      end else begin
        period_r <= '0;
        armed_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      rem_r <= '0;
      quo_r <= clock_r;
      cnt_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_period_r <= period_r;
      out_freq_r   <= (period_r == '0) ? '0 : quo_r;
      out_armed_r  <= armed_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_ticks = out_period_r;
  assign out_frequency_hz = out_freq_r;
  assign out_armed        = out_armed_r;

endmodule

`default_nettype wire

>>> hdl/capture_period_frequency_meter_core.sv
// Frequency meter fed by timer capture requests.
// Input channel (in_valid/in_ready): in_operation 0 carries a capture edge with
// in_captured_count, 1 reports a counter overflow. Each request gives exactly
// one result on the output channel (out_valid/out_ready): period in ticks,
// count_clock_hz divided by the period (0 for a zero period) and the armed flag.
// Config port: cfg_write_en with cfg_index 0 sets the timeout overflow count,
// index 1 the counter clock rate; write only while no request is in flight.
// A small microcode program steps a datapath with a radix-2 restoring divider
// that retires one quotient bit per cycle. The program steps through wait,
// update, divider init, 32 divider iterations (skipped for a zero period),
// emit wait and emit, and takes no new request until the result has been
// loaded. An output register holds the result; while the receiver stalls,
// the program waits before loading the next result.
// Reset (rst_n low, synchronous) disarms the meter, clears the period and
// overflow count, and restores timeout 6408 and clock 84000000.
`timescale 1ns / 1ps
`default_nettype none

module capture_period_frequency_meter_core #(
  parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [cpfm_pkg::CAP_W-1:0]     in_captured_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cpfm_pkg::DATA_W-1:0]         out_period_ticks,
  output logic [cpfm_pkg::DATA_W-1:0]         out_frequency_hz,
  output logic                                out_armed,
  input  wire logic                           cfg_write_en,
  input  wire logic [cpfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpfm_pkg::DATA_W-1:0]    cfg_wdata
);
  import cpfm_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  assign in_ready = ctrl.take_req;

  cpfm_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .status    (status),
    .ctrl      (ctrl)
  );

  cpfm_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .status           (status),
    .req_valid        (in_valid),
    .req_operation    (in_operation),
    .req_count        (in_captured_count),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_period_ticks (out_period_ticks),
    .out_frequency_hz (out_frequency_hz),
    .out_armed        (out_armed)
  );

endmodule

`default_nettype wire

>>> hdl/cpfm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cpfm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [cpfm_pkg::DATA_W-1:0]    out_period_ticks,
  input wire logic [cpfm_pkg::DATA_W-1:0]    out_frequency_hz,
  input wire logic                           out_armed
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request taken while previous request in flight");

  a_zero_period_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_period_ticks == '0) |-> (out_frequency_hz == '0))
    else $error("nonzero frequency with zero period");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_period_ticks) && $stable(out_frequency_hz)
      && $stable(out_armed))
    else $error("result changed while stalled");

endmodule

bind capture_period_frequency_meter_core cpfm_checker u_chk (.*);

`default_nettype wire

>>> bench/capture_period_frequency_meter_core_tb.sv
`timescale 1ns / 1ps

module capture_period_frequency_meter_core_tb;
  import cpfm_pkg::*;

  localparam int CNT_BITS = COUNTER_BITS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int SEG_ITEMS = 100;
  localparam int NUM_ROWS = 28;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] freq;
    logic              armed;
  } reading_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                op;
    logic [CAP_W-1:0]    cap;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]   data;
    logic                fixed;
    reading_t            typed;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_CAPTURE;
  logic [CAP_W-1:0] in_captured_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] out_period_ticks;
  logic [DATA_W-1:0] out_frequency_hz;
  logic out_armed;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic              m_armed = 1'b0;
  logic [CAP_W-1:0]  m_last_cap = '0;
  logic [TMO_W-1:0]  m_ovf_cnt = '0;
  logic [DATA_W-1:0] m_period = '0;
  logic [TMO_W-1:0]  m_timeout = TIMEOUT_RESET;
  logic [DATA_W-1:0] m_clock_hz = CLOCK_RESET;

  reading_t pending_readings[$];
  reading_t head_reading;
  int mismatches = 0;
  int stall_pct = 0;
  int idle_pct = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  script_row_t script_rows [NUM_ROWS] = '{
    '{ROW_REQ, OP_OVERFLOW, 16'hFFFF, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ROW_REQ, OP_CAPTURE, 16'h0000, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_REQ, OP_CAPTURE, 16'hFFFF, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'hFFFF, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'h5A5A, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ROW_REQ, OP_OVERFLOW, 16'hA5A5, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ROW_REQ, OP_CAPTURE, 16'h1234, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_TIMEOUT, 32'h0000FFFF, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_CLOCK, 32'hFFFFFFFF, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'h8000, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'h7FFF, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_CLOCK, 32'd1, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'h7FFE, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_CLOCK, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_CAPTURE, 16'h0001, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_TIMEOUT, 32'd2, 1'b0, '0},
    '{ROW_CFG, OP_CAPTURE, 16'h0000, REG_CLOCK, CLOCK_RESET, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'h0000, REG_TIMEOUT, 32'd0, 1'b0, '0},
    '{ROW_REQ, OP_OVERFLOW, 16'hFFFF, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ROW_REQ, OP_CAPTURE, 16'hC3C3, REG_TIMEOUT, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}}
  };

  capture_period_frequency_meter_core #(
    .COUNTER_BITS(CNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_captured_count(in_captured_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_period_ticks(out_period_ticks),
    .out_frequency_hz(out_frequency_hz),
    .out_armed(out_armed),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reading_t meter_predict(input logic op, input logic [CAP_W-1:0] cap);
    logic [63:0] span;
    logic [63:0] ticks;
    logic [CAP_W-1:0] capm;
    reading_t r;
    span = (64'd1 << CNT_BITS) - 64'd1;
    capm = cap & span[CAP_W-1:0];
    if (op == OP_CAPTURE) begin
      if (m_armed) begin
        ticks = {48'd0, capm} + ({48'd0, m_ovf_cnt} << CNT_BITS) - {48'd0, m_last_cap};
        m_period = ticks[DATA_W-1:0];
      end
      m_last_cap = capm;
      m_ovf_cnt = '0;
      m_armed = 1'b1;
    end else if (m_ovf_cnt < m_timeout) begin
      m_ovf_cnt = m_ovf_cnt + TMO_W'(1);
    end else begin
      m_period = '0;
      m_armed = 1'b0;
    end
    r.period = m_period;
    r.freq = (m_period != '0) ? m_clock_hz / m_period : '0;
    r.armed = m_armed;
    return r;
  endfunction

  task automatic send_req(input logic op, input logic [CAP_W-1:0] cap, input logic fixed,
                          input reading_t typed);
    reading_t got;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 48)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_captured_count <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = meter_predict(op, cap);
    pending_readings.push_back(fixed ? typed : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_TIMEOUT) m_timeout = data[TMO_W-1:0];
    else m_clock_hz = data;
    @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [DATA_W-1:0] tmo;
    logic [DATA_W-1:0] hz;
    case ($urandom_range(0, 5))
      0: tmo = 32'd0;
      1: tmo = 32'h0000FFFF;
      default: tmo = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 5))
      0: hz = 32'hFFFFFFFF;
      1: hz = 32'd1;
      2: hz = $urandom;
      default: hz = $urandom_range(1000, 200000000);
    endcase
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_CLOCK, hz);
  endtask

  task automatic run_segment();
    int sent;
    int n;
    sent = 0;
    while (sent < SEG_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(1'($urandom_range(0, 1)), CAP_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0 && m_timeout <= 12)
          n = $urandom_range(m_timeout, m_timeout + 2);
        else
          n = $urandom_range(0, 2);
        repeat (n) send_req(OP_OVERFLOW, CAP_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        send_req(OP_CAPTURE, CAP_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        sent += n + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result period %h freq %h armed %b", $time,
                 out_period_ticks, out_frequency_hz, out_armed);
        mismatches++;
      end else begin
        head_reading = pending_readings.pop_front();
        if (out_period_ticks !== head_reading.period) begin
          $display("%0t: period expected %h got %h", $time, head_reading.period,
                   out_period_ticks);
          mismatches++;
        end
        if (out_frequency_hz !== head_reading.freq) begin
          $display("%0t: frequency expected %h got %h", $time, head_reading.freq,
                   out_frequency_hz);
          mismatches++;
        end
        if (out_armed !== head_reading.armed) begin
          $display("%0t: armed expected %b got %b", $time, head_reading.armed, out_armed);
          mismatches++;
        end
      end
    end
    if (ready_hold == 0) begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      ready_hold <= $urandom_range(1, 40);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (script_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        send_req(script_rows[i].op, script_rows[i].cap, script_rows[i].fixed,
                 script_rows[i].typed);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 64; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 64; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        pick_settings();
        run_segment();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
